@@ rtl/core/dtlp_pkg.sv @@
package dtlp_pkg;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters the parser reacts to
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam int unsigned PAGE_BITS = 64;
    localparam int unsigned LINE_BITS = 32;

    typedef enum logic [2:0] {
        ST_PAGE  = 3'd0,
        ST_DONE  = 3'd1,
        ST_NEG   = 3'd2,
        ST_NAN   = 3'd3,
        ST_OVF   = 3'd4,
        ST_TRAIL = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        MODE_LEAD    = 3'd0,
        MODE_DIGITS  = 3'd1,
        MODE_TAIL_WS = 3'd2,
        MODE_SKIP    = 3'd3,
        MODE_ERRWAIT = 3'd4
    } t_line_mode;

    typedef struct packed {
        t_status                status;
        logic [PAGE_BITS-1:0]   page_id;
        logic [LINE_BITS-1:0]   line_no;
        logic                   last;
    } t_result;

    // Up to two results per input item: res0 first, then res1
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push_req;

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};
    endfunction

endpackage

@@ rtl/core/dtlp_ifs.sv @@
interface dtlp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_value;

    modport source (output valid, output kind, output byte_value, input ready);
    modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface dtlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] page_id;
    logic [31:0] line_no;
    logic        last;

    modport source (output valid, output status, output page_id, output line_no,
                    output last, input ready);
    modport sink   (input valid, input status, input page_id, input line_no,
                    input last, output ready);
endinterface

@@ rtl/core/decimal_trace_line_parser_unit.sv @@
// Channel   Dir  Payload                                      Accepted when
// i_in_ch   in   kind, byte_value                              valid && ready
// o_out_ch  out  status, page_id, line_no, last                valid && ready
//
// One input item per cycle: the line state and the times-ten accumulate update together
// as each item is taken, so a byte is taken every clock while the result queue has room.
// Results sit in a four-entry queue; ready drops only when fewer than two slots are
// free (end of input may cause a page result and a done result from one item).
// Reset (i_rst_n low at a clock edge, synchronous) returns to line start and clears
// the line count, the error and the stopped flag; the queue empties.
// After a done or error result, further items are still accepted but dropped.
module decimal_trace_line_parser_unit
    import dtlp_pkg::*;
#(
    parameter int unsigned LINE_COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dtlp_in_if.sink     i_in_ch,
    dtlp_out_if.source  o_out_ch
);

    logic      take;
    logic      room;
    t_push_req push;

    // Accept whenever the queue can absorb the worst case of one item
    assign i_in_ch.ready = room;
    assign take          = i_in_ch.valid && room;

    // Line parser: whitespace, comment and digit handling, line counting
    dtlp_line_core #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_kind       (i_in_ch.kind),
        .i_byte_value (i_in_ch.byte_value),
        .o_push       (push)
    );

    // Result queue: holds finished items until the sink takes them
    dtlp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out_ch)
    );

endmodule

@@ rtl/core/dtlp_line_core.sv @@
module dtlp_line_core
    import dtlp_pkg::*;
#(
    parameter int unsigned LINE_COUNT_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_kind,
    input  logic [7:0] i_byte_value,
    output t_push_req  o_push
);

    localparam logic [LINE_COUNT_BITS-1:0] CountMax = '1;

    t_line_mode                 r_mode,       n_mode;
    logic [PAGE_BITS-1:0]       r_acc,        n_acc;
    t_status                    r_err,        n_err;
    logic [LINE_COUNT_BITS-1:0] r_line_count, n_line_count;
    logic                       r_has_bytes,  n_has_bytes;
    logic                       r_stopped,    n_stopped;

    logic                       digit;
    logic [3:0]                 dval;
    logic [PAGE_BITS+3:0]       prod;
    logic                       ovf;
    logic [LINE_COUNT_BITS-1:0] cnt_inc;
    logic [LINE_COUNT_BITS-1:0] cnt_after;
    logic [63:0]                cnt_ext;
    logic [LINE_BITS-1:0]       line_out;
    t_result                    end_res;
    logic                       end_emit;
    logic                       end_stop;
    t_result                    done_res;

    assign digit = (i_byte_value >= CHAR_ZERO) && (i_byte_value <= CHAR_NINE);
    assign dval  = digit ? 4'(i_byte_value - CHAR_ZERO) : 4'd0;
    // acc * 10 + d, overflow shows in the four top bits
    assign prod  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + (PAGE_BITS + 4)'(dval);
    assign ovf   = |prod[PAGE_BITS+3:PAGE_BITS];

    assign cnt_inc = (r_line_count < CountMax) ? r_line_count + 1'b1 : r_line_count;
    // Count after closing the line, if this item closes one
    assign cnt_after = (i_kind == KIND_BYTE || r_has_bytes) ? cnt_inc : r_line_count;
    assign cnt_ext   = 64'(cnt_after);
    assign line_out  = (|cnt_ext[63:32]) ? '1 : cnt_ext[31:0];

    always_comb begin
        end_emit = (r_mode == MODE_DIGITS) || (r_mode == MODE_TAIL_WS) ||
                   (r_mode == MODE_ERRWAIT);
        end_stop = (r_mode == MODE_ERRWAIT);
        end_res.status      = end_stop ? r_err : ST_PAGE;
        end_res.page_id     = end_stop ? '0 : r_acc;
        end_res.line_no     = line_out;
        end_res.last        = end_stop;
        done_res.status      = ST_DONE;
        done_res.page_id     = '0;
        done_res.line_no     = line_out;
        done_res.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_LEAD;
            r_acc        <= '0;
            r_err        <= ST_PAGE;
            r_line_count <= '0;
            r_has_bytes  <= 1'b0;
            r_stopped    <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_acc        <= n_acc;
            r_err        <= n_err;
            r_line_count <= n_line_count;
            r_has_bytes  <= n_has_bytes;
            r_stopped    <= n_stopped;
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_err        = r_err;
        n_line_count = r_line_count;
        n_has_bytes  = r_has_bytes;
        n_stopped    = r_stopped;
        o_push.count = 2'd0;
        o_push.res0  = end_res;
        o_push.res1  = done_res;

        if (i_take && !r_stopped) begin
            if (i_kind == KIND_BYTE && i_byte_value == CHAR_NL) begin
                // Close the line
                n_line_count = cnt_inc;
                n_mode       = MODE_LEAD;
                n_acc        = '0;
                n_err        = ST_PAGE;
                n_has_bytes  = 1'b0;
                n_stopped    = end_stop;
                o_push.count = end_emit ? 2'd1 : 2'd0;
            end else if (i_kind == KIND_BYTE) begin
                n_has_bytes = 1'b1;
                case (r_mode)
                    MODE_LEAD: begin
                        if (!is_blank(i_byte_value)) begin
                            if (i_byte_value == CHAR_HASH) begin
                                n_mode = MODE_SKIP;
                            end else if (i_byte_value == CHAR_MINUS) begin
                                n_mode = MODE_ERRWAIT;
                                n_err  = ST_NEG;
                            end else if (digit) begin
                                n_mode = MODE_DIGITS;
                                n_acc  = PAGE_BITS'(dval);
                            end else begin
                                n_mode = MODE_ERRWAIT;
                                n_err  = ST_NAN;
                            end
                        end
                    end
                    MODE_DIGITS: begin
                        if (digit) begin
                            if (ovf) begin
                                n_mode = MODE_ERRWAIT;
                                n_err  = ST_OVF;
                            end else begin
                                n_acc = prod[PAGE_BITS-1:0];
                            end
                        end else if (is_blank(i_byte_value)) begin
                            n_mode = MODE_TAIL_WS;
                        end else begin
                            n_mode = MODE_ERRWAIT;
                            n_err  = ST_TRAIL;
                        end
                    end
                    MODE_TAIL_WS: begin
                        if (!is_blank(i_byte_value)) begin
                            n_mode = MODE_ERRWAIT;
                            n_err  = ST_TRAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                // End of input: close a pending line, then report done unless that line held an error
                n_line_count = cnt_after;
                n_mode       = MODE_LEAD;
                n_acc        = '0;
                n_err        = ST_PAGE;
                n_has_bytes  = 1'b0;
                n_stopped    = 1'b1;
                if (r_has_bytes && end_emit) begin
                    o_push.res0  = end_res;
                    o_push.count = end_stop ? 2'd1 : 2'd2;
                end else begin
                    o_push.res0  = done_res;
                    o_push.count = 2'd1;
                end
            end
        end
    end

    a_no_push_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && r_stopped) |-> (o_push.count == 2'd0))
        else $error("result produced after stream end");

    a_second_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |-> (o_push.res1.status == ST_DONE && o_push.res1.last &&
                                    o_push.res0.status == ST_PAGE))
        else $error("second result of one item is not page then done");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd0 && o_push.res0.last) |=> r_stopped)
        else $error("final result did not stop the parser");

endmodule

@@ rtl/core/dtlp_res_fifo.sv @@
module dtlp_res_fifo
    import dtlp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push_req     i_push,
    output logic          o_room,
    dtlp_out_if.source    o_out
);

    localparam int unsigned Depth   = 4;
    localparam int unsigned PtrBits = $clog2(Depth);

    t_result              r_mem [Depth];
    logic [PtrBits-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrBits-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PtrBits:0]     r_count,  n_count;
    logic                 pop;
    logic [PtrBits-1:0]   wr_ptr1;
    t_result              head;

    assign pop     = o_out.valid && o_out.ready;
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    // Leave room for the two results one item may cause
    assign o_room  = (r_count <= (PtrBits + 1)'(Depth - 2));

    assign head              = r_mem[r_rd_ptr];
    assign o_out.valid       = (r_count != '0);
    assign o_out.status      = head.status;
    assign o_out.page_id     = head.page_id;
    assign o_out.line_no     = head.line_no;
    assign o_out.last        = head.last;

    always_comb begin
        n_wr_ptr = r_wr_ptr + PtrBits'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (PtrBits + 1)'(i_push.count) - (PtrBits + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PtrBits + 1)'(Depth))
        else $error("result queue count beyond depth");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |->
            ((PtrBits + 2)'(r_count) + (PtrBits + 2)'(i_push.count) <= (PtrBits + 2)'(Depth)))
        else $error("result queue overrun");

    a_double_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2 && !pop) |=> (r_count == $past(r_count) + 2'd2))
        else $error("double push not counted");

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dtlp_pkg::*;

    localparam int unsigned LINE_COUNT_BITS = 32;
    localparam int unsigned ITEM_TARGET     = 1550;
    localparam int unsigned CYCLE_LIMIT     = 400_000;
    localparam int unsigned MAX_PRINTED     = 40;

    // Whitespace bytes that the parser skips around a number
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Tracks the line state the same way the parser does and holds the results
    // it has to produce, oldest first.
    class line_parse_scoreboard;
        t_line_mode                 mode;
        logic [63:0]                acc;
        t_status                    err_code;
        logic [LINE_COUNT_BITS-1:0] line_cnt;
        bit                         has_bytes;
        bit                         halted;
        t_result                    awaited[$];
        int unsigned                mismatches;

        function new();
            mode       = MODE_LEAD;
            acc        = '0;
            err_code   = ST_PAGE;
            line_cnt   = '0;
            has_bytes  = 1'b0;
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        static function bit is_space(logic [7:0] c);
            return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT ||
                   c == CHAR_FF || c == CHAR_CR;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void queue_result(t_status st, logic [63:0] page, bit last);
            t_result     r;
            logic [63:0] wide_cnt;
            wide_cnt      = 64'(line_cnt);
            r.status      = st;
            r.page_id     = page;
            r.line_no     = (wide_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide_cnt[31:0];
            r.last        = last;
            awaited.insert(awaited.size(), r);
        endfunction

        // Close the current line: count it, then emit its page id or the held error, if any.
        function void close_line();
            if (line_cnt != '1)
                line_cnt++;
            if (mode == MODE_DIGITS || mode == MODE_TAIL_WS) begin
                queue_result(ST_PAGE, acc, 1'b0);
            end else if (mode == MODE_ERRWAIT) begin
                queue_result(err_code, '0, 1'b1);
                halted = 1'b1;
            end
            mode      = MODE_LEAD;
            acc       = '0;
            err_code  = ST_PAGE;
            has_bytes = 1'b0;
        endfunction

        function void take_char(logic [7:0] c);
            bit          digit;
            logic [63:0] d;
            digit     = c >= CHAR_ZERO && c <= CHAR_NINE;
            d         = digit ? 64'(c - CHAR_ZERO) : 64'd0;
            has_bytes = 1'b1;
            case (mode)
                MODE_LEAD: begin
                    if (!is_space(c)) begin
                        if (c == CHAR_HASH) begin
                            mode = MODE_SKIP;
                        end else if (c == CHAR_MINUS) begin
                            err_code = ST_NEG;
                            mode     = MODE_ERRWAIT;
                        end else if (digit) begin
                            acc  = d;
                            mode = MODE_DIGITS;
                        end else begin
                            err_code = ST_NAN;
                            mode     = MODE_ERRWAIT;
                        end
                    end
                end
                MODE_DIGITS: begin
                    if (digit) begin
                        if (acc > ({64{1'b1}} - d) / 64'd10) begin
                            err_code = ST_OVF;
                            mode     = MODE_ERRWAIT;
                        end else begin
                            acc = acc * 64'd10 + d;
                        end
                    end else if (is_space(c)) begin
                        mode = MODE_TAIL_WS;
                    end else begin
                        err_code = ST_TRAIL;
                        mode     = MODE_ERRWAIT;
                    end
                end
                MODE_TAIL_WS: begin
                    if (!is_space(c)) begin
                        err_code = ST_TRAIL;
                        mode     = MODE_ERRWAIT;
                    end
                end
                default: ;
            endcase
        endfunction

        // Apply one accepted item; once stopped, drop everything.
        function void note_item(logic kind, logic [7:0] c);
            if (halted)
                return;
            if (kind == KIND_BYTE) begin
                if (c == CHAR_NL)
                    close_line();
                else
                    take_char(c);
            end else begin
                if (has_bytes)
                    close_line();
                if (!halted) begin
                    queue_result(ST_DONE, '0, 1'b1);
                    halted = 1'b1;
                end
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_result(t_result got);
            t_result want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result status %0d page %0d line %0d last %0d",
                                 got.status, got.page_id, got.line_no, got.last));
                return;
            end
            want = awaited.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.page_id != want.page_id)
                report($sformatf("page_id %0d, want %0d", got.page_id, want.page_id));
            if (got.line_no != want.line_no)
                report($sformatf("line_no %0d, want %0d", got.line_no,
                                 want.line_no));
            if (got.last != want.last)
                report($sformatf("last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dtlp_in_if  in_ch();
    dtlp_out_if out_ch();

    decimal_trace_line_parser_unit #(
        .LINE_COUNT_BITS(LINE_COUNT_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    line_parse_scoreboard results = new();

    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned ready_run   = 0;
    int unsigned ready_stall = 0;
    int unsigned cycle_count = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Note inputs before checking outputs so the order within an edge is fixed.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                results.note_item(in_ch.kind, in_ch.byte_value);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                results.check_result({out_ch.status, out_ch.page_id, out_ch.line_no,
                                      out_ch.last});
        end
    end

    // Receiver: runs of ready with short stalls, now and then a long open stretch.
    always @(negedge i_clk) begin
        if (ready_run > 0) begin
            out_ch.ready = 1'b1;
            ready_run--;
        end else if (ready_stall > 0) begin
            out_ch.ready = 1'b0;
            ready_stall--;
        end else begin
            ready_run   = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                      : $urandom_range(1, 10);
            ready_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            out_ch.ready = 1'b1;
        end
    end

    // Present one item at a falling edge and hold it until accepted; between
    // bursts drop valid for a random gap.
    task automatic drive_item(input logic kind, input logic [7:0] value);
        in_ch.valid      = 1'b1;
        in_ch.kind       = kind;
        in_ch.byte_value = value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        items_sent++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_ch.valid      = 1'b0;
            in_ch.kind       = 1'($urandom);
            in_ch.byte_value = 8'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        drive_item(KIND_BYTE, value);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 4))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            3:       return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    // Any byte that does not end the line
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do c = 8'($urandom); while (c == CHAR_NL);
        return c;
    endfunction

    // A byte that cannot start or continue a number
    function automatic logic [7:0] junk_char(input bit allow_sign);
        logic [7:0] c;
        do c = 8'($urandom);
        while (c == CHAR_NL || line_parse_scoreboard::is_space(c) ||
               (c >= CHAR_ZERO && c <= CHAR_NINE) ||
               (!allow_sign && (c == CHAR_HASH || c == CHAR_MINUS)));
        return c;
    endfunction

    function automatic logic [63:0] rand_page();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    task automatic send_blanks(input int unsigned max_len);
        repeat ($urandom_range(0, max_len)) send_byte(blank_char());
    endtask

    task automatic send_number(input logic [63:0] value, input int unsigned zeros);
        logic [7:0]  digits [20];
        int          n;
        logic [63:0] v;
        n = 0;
        v = value;
        repeat (zeros) send_byte(CHAR_ZERO);
        do begin
            digits[n] = CHAR_ZERO + 8'(v % 64'd10);
            v         = v / 64'd10;
            n++;
        end while (v != 0);
        for (int i = n - 1; i >= 0; i--)
            send_byte(digits[i]);
    endtask

    task automatic send_comment(input int unsigned max_len);
        send_byte(CHAR_HASH);
        repeat ($urandom_range(0, max_len)) send_byte(text_char());
    endtask

    // One line that keeps the stream going: blank, comment or a page id.
    task automatic send_good_line();
        send_blanks(3);
        case ($urandom_range(0, 9))
            0: ;
            1: send_comment(12);
            2: send_number($urandom_range(0, 1) ? {64{1'b1}} : 64'd0, $urandom_range(0, 3));
            default: send_number(rand_page(), ($urandom_range(0, 5) == 0) ? 2 : 0);
        endcase
        send_blanks(3);
        send_byte(CHAR_NL);
    endtask

    // Close the stream: a clean end of input, an unterminated last line, or one
    // of the error lines, which stop the parser for good.
    task automatic send_stream_end();
        bit by_newline;
        by_newline = $urandom_range(0, 1);
        case ($urandom_range(0, 8))
            0: drive_item(KIND_END, 8'($urandom));
            1: begin
                send_blanks(2);
                send_number(rand_page(), 0);
                send_blanks(2);
                drive_item(KIND_END, 8'($urandom));
            end
            2: begin
                send_byte(blank_char());
                send_blanks(3);
                drive_item(KIND_END, 8'($urandom));
            end
            3: begin
                send_blanks(2);
                send_comment(8);
                drive_item(KIND_END, 8'($urandom));
            end
            4: begin
                // leading minus
                send_blanks(2);
                send_byte(CHAR_MINUS);
                send_number(rand_page(), 0);
                if (by_newline) send_byte(CHAR_NL); else drive_item(KIND_END, 8'($urandom));
            end
            5: begin
                // no leading digit, including a zero byte or a high byte
                send_blanks(2);
                send_byte(junk_char(1'b0));
                send_number(rand_page(), 0);
                if (by_newline) send_byte(CHAR_NL); else drive_item(KIND_END, 8'($urandom));
            end
            6: begin
                // overflow wins over the text that follows
                send_blanks(2);
                if ($urandom_range(0, 1)) begin
                    send_text("18446744073709551616");
                end else begin
                    send_number({64{1'b1}}, 0);
                    send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 1)) begin
                    send_byte(junk_char(1'b1));
                    send_blanks(2);
                    send_byte(text_char());
                end
                if (by_newline) send_byte(CHAR_NL); else drive_item(KIND_END, 8'($urandom));
            end
            7: begin
                // text right after the digits
                send_blanks(2);
                send_number(rand_page(), 0);
                send_byte(junk_char(1'b1));
                if (by_newline) send_byte(CHAR_NL); else drive_item(KIND_END, 8'($urandom));
            end
            default: begin
                // text after inner whitespace
                send_number(rand_page(), 0);
                send_byte(blank_char());
                send_blanks(2);
                do send_byte(text_char()); while ($urandom_range(0, 1));
                if (by_newline) send_byte(CHAR_NL); else drive_item(KIND_END, 8'($urandom));
            end
        endcase
    endtask

    // Hold the sender until every expected result has come out.
    task automatic hold_until_drained();
        in_ch.valid = 1'b0;
        do @(negedge i_clk); while (results.pending() != 0);
    endtask

    initial begin
        bit drained_once;
        drained_once     = 1'b0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_BYTE;
        in_ch.byte_value = 8'h00;
        out_ch.ready     = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed lines: smallest and largest page id, every blank byte around
        // a number, a comment, an empty line and CR before LF.
        send_text("0\n");
        send_text("18446744073709551615\n");
        send_byte(CHAR_SPACE);
        send_byte(CHAR_TAB);
        send_byte(CHAR_VT);
        send_byte(CHAR_FF);
        send_text("7 ");
        send_byte(CHAR_CR);
        send_byte(CHAR_NL);
        send_text("#-x\n");
        send_text("\n");
        send_text("007\r\n");

        while (items_sent < ITEM_TARGET) begin
            send_good_line();
            if (!drained_once && items_sent > ITEM_TARGET / 2) begin
                hold_until_drained();
                drained_once = 1'b1;
            end
        end
        send_stream_end();

        // After the stream has stopped, items are taken and dropped.
        repeat (20) drive_item(1'($urandom), 8'($urandom));
        in_ch.valid = 1'b0;

        while (results.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (results.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
